// ===== rtl/bam_pkg.sv =====
package bam_pkg;

   localparam int PIX_W  = 8;
   localparam int SUM_W  = 20;
   localparam int CH_N   = 4;
   localparam int CFG_W  = 12;
   localparam int CIDX_W = 2;
   localparam int STEP_W = 5;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int MAX_BLOCK  = 64;

   localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd0;
   localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd1;
   localparam logic [CIDX_W-1:0] CFG_BLOCK  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic update;
      logic div_step;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic div_last;
   } status_type;

endpackage

// ===== rtl/bam_ram.sv =====
module bam_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bam_ctrl.sv =====
module bam_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  bam_pkg::status_type status,
   output bam_pkg::cmd_type    cmd
);

   bam_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bam_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         bam_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = bam_pkg::ST_READ;
            end
         end
         bam_pkg::ST_READ: begin
            cmd.update = 1'b1;
            state_in   = status.emit ? bam_pkg::ST_DIV : bam_pkg::ST_IDLE;
         end
         bam_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = bam_pkg::ST_OUT;
            end
         end
         bam_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = bam_pkg::ST_IDLE;
            end
         end
         default: state_in = bam_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/bam_datapath.sv =====
module bam_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bam_pkg::CIDX_W-1:0]        csr_index,
   input  logic [bam_pkg::CFG_W-1:0]         csr_data,
   input  logic [bam_pkg::PIX_W-1:0]         req_red,
   input  logic [bam_pkg::PIX_W-1:0]         req_green,
   input  logic [bam_pkg::PIX_W-1:0]         req_blue,
   input  logic [bam_pkg::PIX_W-1:0]         req_alpha,
   output logic [10:0]                       rsp_block_col,
   output logic [10:0]                       rsp_block_row,
   output logic [6:0]                        rsp_block_width,
   output logic [6:0]                        rsp_block_height,
   output logic [bam_pkg::PIX_W-1:0]         rsp_avg_red,
   output logic [bam_pkg::PIX_W-1:0]         rsp_avg_green,
   output logic [bam_pkg::PIX_W-1:0]         rsp_avg_blue,
   output logic [bam_pkg::PIX_W-1:0]         rsp_avg_alpha,
   output logic                              rsp_frame_done,
   input  bam_pkg::cmd_type                  cmd,
   output bam_pkg::status_type               status
);

   localparam int COL_W = $clog2(bam_pkg::MAX_WIDTH);
   localparam int ROW_W = $clog2(bam_pkg::MAX_HEIGHT);
   localparam int BLK_W = $clog2(bam_pkg::MAX_BLOCK);
   localparam int CNT_W = 2 * (BLK_W + 1);
   localparam int SW    = bam_pkg::SUM_W;
   localparam int NCH   = bam_pkg::CH_N;
   localparam int PW    = bam_pkg::PIX_W;

   logic [bam_pkg::CFG_W-1:0] width_ff, height_ff;
   logic [6:0]                block_ff;

   logic [COL_W-1:0] pcol_ff, pcol_in;
   logic [ROW_W-1:0] prow_ff, prow_in;
   logic [BLK_W-1:0] cwb_ff, cwb_in, rwb_ff, rwb_in;
   logic [COL_W-1:0] bcol_ff, bcol_in;
   logic [ROW_W-1:0] brow_ff, brow_in;

   logic [COL_W:0] w_eff;
   logic [ROW_W:0] h_eff;
   logic [BLK_W:0] bs_eff;
   logic           csr_hit;

   always_comb begin
      if (width_ff == '0) w_eff = (COL_W+1)'(1);
      else if (32'(width_ff) > bam_pkg::MAX_WIDTH) w_eff = (COL_W+1)'(bam_pkg::MAX_WIDTH);
      else w_eff = (COL_W+1)'(width_ff);
      if (height_ff == '0) h_eff = (ROW_W+1)'(1);
      else if (32'(height_ff) > bam_pkg::MAX_HEIGHT) h_eff = (ROW_W+1)'(bam_pkg::MAX_HEIGHT);
      else h_eff = (ROW_W+1)'(height_ff);
      if (block_ff == '0) bs_eff = (BLK_W+1)'(1);
      else if (32'(block_ff) > bam_pkg::MAX_BLOCK) bs_eff = (BLK_W+1)'(bam_pkg::MAX_BLOCK);
      else bs_eff = (BLK_W+1)'(block_ff);
   end

   assign csr_hit = csr_we && (csr_index == bam_pkg::CFG_WIDTH ||
                               csr_index == bam_pkg::CFG_HEIGHT ||
                               csr_index == bam_pkg::CFG_BLOCK);

   logic last_col, last_row, cwb_end, rwb_end, emit_now;
   logic [BLK_W:0] bw, bh;

   always_comb begin
      last_col = ((COL_W+1)'(pcol_ff) + 1'b1) == w_eff;
      last_row = ((ROW_W+1)'(prow_ff) + 1'b1) == h_eff;
      bw       = (BLK_W+1)'(cwb_ff) + 1'b1;
      bh       = (BLK_W+1)'(rwb_ff) + 1'b1;
      cwb_end  = bw == bs_eff;
      rwb_end  = bh == bs_eff;
      emit_now = (last_col || cwb_end) && (last_row || rwb_end);

      pcol_in = pcol_ff;
      prow_in = prow_ff;
      cwb_in  = cwb_ff;
      rwb_in  = rwb_ff;
      bcol_in = bcol_ff;
      brow_in = brow_ff;
      if (last_col) begin
         pcol_in = '0;
         cwb_in  = '0;
         bcol_in = '0;
         if (last_row) begin
            prow_in = '0;
            rwb_in  = '0;
            brow_in = '0;
         end else begin
            prow_in = prow_ff + 1'b1;
            if (rwb_end) begin
               rwb_in  = '0;
               brow_in = brow_ff + 1'b1;
            end else begin
               rwb_in = rwb_ff + 1'b1;
            end
         end
      end else begin
         pcol_in = pcol_ff + 1'b1;
         if (cwb_end) begin
            cwb_in  = '0;
            bcol_in = bcol_ff + 1'b1;
         end else begin
            cwb_in = cwb_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bam_pkg::CFG_W'(640);
         height_ff <= bam_pkg::CFG_W'(480);
         block_ff  <= 7'd8;
         pcol_ff   <= '0;
         prow_ff   <= '0;
         cwb_ff    <= '0;
         rwb_ff    <= '0;
         bcol_ff   <= '0;
         brow_ff   <= '0;
      end else if (csr_hit) begin
         unique case (csr_index)
            bam_pkg::CFG_WIDTH:  width_ff  <= csr_data;
            bam_pkg::CFG_HEIGHT: height_ff <= csr_data;
            bam_pkg::CFG_BLOCK:  block_ff  <= csr_data[6:0];
            default: ;
         endcase
         // restart the frame, leave sums alone
         pcol_ff <= '0;
         prow_ff <= '0;
         cwb_ff  <= '0;
         rwb_ff  <= '0;
         bcol_ff <= '0;
         brow_ff <= '0;
      end else if (cmd.accept) begin
         pcol_ff <= pcol_in;
         prow_ff <= prow_in;
         cwb_ff  <= cwb_in;
         rwb_ff  <= rwb_in;
         bcol_ff <= bcol_in;
         brow_ff <= brow_in;
      end
   end

   // per-request captured context
   logic [PW-1:0]    px_ff [NCH];
   logic             first_ff, emit_ff, done_ff;
   logic [COL_W-1:0] idx_ff;
   logic [ROW_W-1:0] brow_cap_ff;
   logic [BLK_W:0]   bw_ff, bh_ff;
   logic [CNT_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff[0]    <= req_red;
         px_ff[1]    <= req_green;
         px_ff[2]    <= req_blue;
         px_ff[3]    <= req_alpha;
         first_ff    <= (cwb_ff == '0) && (rwb_ff == '0);
         emit_ff     <= emit_now;
         done_ff     <= last_col && last_row;
         idx_ff      <= bcol_ff;
         brow_cap_ff <= brow_ff;
         bw_ff       <= bw;
         bh_ff       <= bh;
         cnt_ff      <= CNT_W'(bw) * CNT_W'(bh);
      end
   end

   logic [NCH*SW-1:0] rd_data, wr_data;
   logic [SW-1:0]     sum [NCH];

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         if (first_ff) sum[c] = SW'(px_ff[c]);
         else sum[c] = rd_data[c*SW +: SW] + SW'(px_ff[c]);
         wr_data[c*SW +: SW] = sum[c];
      end
   end

   bam_ram #(
      .WIDTH(NCH * SW),
      .DEPTH(bam_pkg::MAX_WIDTH)
   ) u_sum_ram (
      .clock  (clock),
      .wr_en  (cmd.update),
      .wr_addr(idx_ff),
      .wr_data(wr_data),
      .rd_en  (cmd.accept),
      .rd_addr(bcol_ff),
      .rd_data(rd_data)
   );

   // restoring divider, one quotient bit per cycle on all channels
   logic [SW-1:0]             quo_ff [NCH];
   logic [CNT_W-1:0]          rem_ff [NCH];
   logic [bam_pkg::STEP_W-1:0] step_ff;
   logic [CNT_W:0]            rem_sh [NCH];
   logic [CNT_W:0]            diff [NCH];

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         rem_sh[c] = {rem_ff[c], quo_ff[c][SW-1]};
         diff[c]   = rem_sh[c] - {1'b0, cnt_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         step_ff <= bam_pkg::STEP_W'(SW - 1);
         for (int c = 0; c < NCH; c++) begin
            quo_ff[c] <= sum[c];
            rem_ff[c] <= '0;
         end
      end else if (cmd.div_step) begin
         step_ff <= step_ff - 1'b1;
         for (int c = 0; c < NCH; c++) begin
            if (!diff[c][CNT_W]) begin
               rem_ff[c] <= diff[c][CNT_W-1:0];
               quo_ff[c] <= {quo_ff[c][SW-2:0], 1'b1};
            end else begin
               rem_ff[c] <= rem_sh[c][CNT_W-1:0];
               quo_ff[c] <= {quo_ff[c][SW-2:0], 1'b0};
            end
         end
      end
   end

   assign status.emit     = emit_ff;
   assign status.div_last = step_ff == '0;

   assign rsp_block_col    = 11'(idx_ff);
   assign rsp_block_row    = 11'(brow_cap_ff);
   assign rsp_block_width  = 7'(bw_ff);
   assign rsp_block_height = 7'(bh_ff);
   assign rsp_avg_red      = quo_ff[0][PW-1:0];
   assign rsp_avg_green    = quo_ff[1][PW-1:0];
   assign rsp_avg_blue     = quo_ff[2][PW-1:0];
   assign rsp_avg_alpha    = quo_ff[3][PW-1:0];
   assign rsp_frame_done   = done_ff;

endmodule

// ===== rtl/block_average_mosaic_core.sv =====
// A pixel that ends a block raises rsp_valid after acceptance, once the sum RAM
// read-modify-write and then the bit-serial divider are done.
// Pixels are taken only in idle: one that ends no block waits on the sum RAM
// read-modify-write; one that ends a block also on the 20-step divider and rsp_ready.
// Reset: synchronous, active high; registers return to 640x480, block 8, frame
// start. Sum RAM is not cleared; each entry is written by the first pixel of a block.
module block_average_mosaic_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_alpha,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_block_col,
   output logic [10:0] rsp_block_row,
   output logic [6:0]  rsp_block_width,
   output logic [6:0]  rsp_block_height,
   output logic [7:0]  rsp_avg_red,
   output logic [7:0]  rsp_avg_green,
   output logic [7:0]  rsp_avg_blue,
   output logic [7:0]  rsp_avg_alpha,
   output logic        rsp_frame_done
);

   bam_pkg::cmd_type    cmd;
   bam_pkg::status_type status;

   bam_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   bam_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_alpha       (req_alpha),
      .rsp_block_col   (rsp_block_col),
      .rsp_block_row   (rsp_block_row),
      .rsp_block_width (rsp_block_width),
      .rsp_block_height(rsp_block_height),
      .rsp_avg_red     (rsp_avg_red),
      .rsp_avg_green   (rsp_avg_green),
      .rsp_avg_blue    (rsp_avg_blue),
      .rsp_avg_alpha   (rsp_avg_alpha),
      .rsp_frame_done  (rsp_frame_done),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
